[hw/rtl/nfpa_pkg.sv]
`default_nettype none

package nfpa_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int CFG_W   = 5;
    localparam int INDEX_W = 4;
    localparam int REQ_W   = 16;
    localparam int DATA_W  = 24;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/next_fit_partition_allocator.sv]
// channel  | direction | handshake          | word
// ---------+-----------+--------------------+--------------------------------------
// s_       | in        | s_tvalid/s_tready  | tuser: cmd; tdata: block_index, size
// m_       | out       | m_tvalid/m_tready  | tuser: granted; tdata: block_number,
//          |           |                    |        remaining
// cfg_     | in        | cfg_valid/cfg_ready| cfg_data: block_count
//
// Load word: accepted, no result.
// Allocate word: one partition compared per cycle by the single compare/subtract unit
// against the registered read port.
// Busy (s_tready low) from allocate accept until its result sits in the output register.
// aresetn (synchronous, active low) clears the table valid bits, rover and block_count.
// A finished result waits in S_DONE while the output register is held; no word is taken.
`default_nettype none

module next_fit_partition_allocator #(
    parameter int MAX_BLOCKS = nfpa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = nfpa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [nfpa_pkg::CFG_W-1:0] cfg_data,   // block_count

    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic                        s_tuser,   // cmd
    input  wire logic [nfpa_pkg::DATA_W-1:0] s_tdata,   // [3:0] block_index, [19:4] size

    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic                             m_tuser,   // granted
    output logic [nfpa_pkg::DATA_W-1:0]      m_tdata    // [3:0] block_number, [19:4] remaining
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (SIZE_BITS > nfpa_pkg::REQ_W) ? SIZE_BITS : nfpa_pkg::REQ_W;
    localparam logic [CMP_W-1:0] SPACE_MAX = CMP_W'((64'd1 << SIZE_BITS) - 64'd1);

    nfpa_pkg::state_t state_reg, state_next;

    logic [nfpa_pkg::CFG_W-1:0] block_count_reg;
    logic [IDX_W-1:0]           rover_reg, rover_next;
    logic [IDX_W-1:0]           ptr_reg, ptr_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CMP_W-1:0]           req_reg, req_next;
    logic [MAX_BLOCKS-1:0]      valid_reg, valid_next;
    logic [SIZE_BITS-1:0]       rd_data_reg;
    logic                       rd_valid_reg;

    logic                           res_granted_reg, res_granted_next;
    logic [nfpa_pkg::INDEX_W-1:0]   res_num_reg, res_num_next;
    logic [nfpa_pkg::REQ_W-1:0]     res_rem_reg, res_rem_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        m_tuser_reg, m_tuser_next;
    logic [nfpa_pkg::DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];

    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [SIZE_BITS-1:0]         mem_wdata;
    logic [IDX_W-1:0]             rd_addr;

    logic                         s_accept;
    logic [nfpa_pkg::INDEX_W-1:0] in_index;
    logic [nfpa_pkg::REQ_W-1:0]   in_size;
    logic [CNT_W-1:0]             used_count;
    logic [IDX_W-1:0]             start_ptr;
    logic [IDX_W-1:0]             ptr_inc;
    logic [CMP_W-1:0]             cur_data;
    logic                         fits;
    logic [SIZE_BITS-1:0]         new_free;
    logic [SIZE_BITS-1:0]         load_val;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == nfpa_pkg::S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;

    assign s_accept = s_tvalid && s_tready;
    assign in_index = s_tdata[nfpa_pkg::INDEX_W-1:0];
    assign in_size  = s_tdata[nfpa_pkg::INDEX_W +: nfpa_pkg::REQ_W];

    assign used_count = (32'(block_count_reg) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                            : CNT_W'(block_count_reg);
    assign start_ptr  = (CNT_W'(rover_reg) < used_count) ? rover_reg : '0;
    assign ptr_inc    = ((CNT_W'(ptr_reg) + CNT_W'(1)) == cnt_reg) ? '0
                                                                    : ptr_reg + IDX_W'(1);
    assign cur_data   = rd_valid_reg ? CMP_W'(rd_data_reg) : '0;
    assign fits       = (cur_data >= req_reg);
    assign new_free   = SIZE_BITS'(cur_data - req_reg);
    assign load_val   = (CMP_W'(in_size) > SPACE_MAX) ? SIZE_BITS'(SPACE_MAX)
                                                      : SIZE_BITS'(in_size);

    always_comb begin
        state_next       = state_reg;
        rover_next       = rover_reg;
        ptr_next         = ptr_reg;
        k_next           = k_reg;
        cnt_next         = cnt_reg;
        req_next         = req_reg;
        valid_next       = valid_reg;
        res_granted_next = res_granted_reg;
        res_num_next     = res_num_reg;
        res_rem_next     = res_rem_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tuser_next     = m_tuser_reg;
        m_tdata_next     = m_tdata_reg;
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg;
        mem_wdata        = new_free;
        rd_addr          = ptr_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            nfpa_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == nfpa_pkg::CMD_LOAD) begin
                        if (32'(in_index) < MAX_BLOCKS) begin
                            mem_we                         = 1'b1;
                            mem_waddr                      = IDX_W'(in_index);
                            mem_wdata                      = load_val;
                            valid_next[IDX_W'(in_index)]   = 1'b1;
                            rover_next                     = '0;
                        end
                    end else begin
                        req_next         = CMP_W'(in_size);
                        cnt_next         = used_count;
                        ptr_next         = start_ptr;
                        k_next           = '0;
                        res_granted_next = 1'b0;
                        res_num_next     = '0;
                        res_rem_next     = '0;
                        state_next       = (used_count == '0) ? nfpa_pkg::S_DONE
                                                              : nfpa_pkg::S_READ;
                    end
                end
            end
            nfpa_pkg::S_READ: begin
                state_next = nfpa_pkg::S_SCAN;
            end
            nfpa_pkg::S_SCAN: begin
                if (fits) begin
                    mem_we              = 1'b1;
                    valid_next[ptr_reg] = 1'b1;
                    rover_next          = ptr_reg;
                    res_granted_next    = 1'b1;
                    res_num_next        = nfpa_pkg::INDEX_W'(ptr_reg);
                    res_rem_next        = nfpa_pkg::REQ_W'(new_free);
                    state_next          = nfpa_pkg::S_DONE;
                end else if (k_reg == cnt_reg - CNT_W'(1)) begin
                    state_next = nfpa_pkg::S_DONE;
                end else begin
                    k_next   = k_reg + CNT_W'(1);
                    ptr_next = ptr_inc;
                    rd_addr  = ptr_inc;
                end
            end
            nfpa_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_granted_reg;
                    m_tdata_next  = nfpa_pkg::DATA_W'({res_rem_reg, res_num_reg});
                    state_next    = nfpa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = nfpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= nfpa_pkg::S_IDLE;
            block_count_reg <= '0;
            rover_reg       <= '0;
            valid_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rover_reg    <= rover_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                block_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg         <= ptr_next;
        k_reg           <= k_next;
        cnt_reg         <= cnt_next;
        req_reg         <= req_next;
        rd_valid_reg    <= valid_reg[rd_addr];
        res_granted_reg <= res_granted_next;
        res_num_reg     <= res_num_next;
        res_rem_reg     <= res_rem_next;
        m_tuser_reg     <= m_tuser_next;
        m_tdata_reg     <= m_tdata_next;
    end

endmodule

`default_nettype wire

[hw/rtl/nfpa_checker.sv]
`default_nettype none

module nfpa_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        s_tuser,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic                        m_tuser,
    input wire logic [nfpa_pkg::DATA_W-1:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not granted word carries nonzero data");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == nfpa_pkg::CMD_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("load word produced a result");

    a_alloc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == nfpa_pkg::CMD_ALLOC) |=> !s_tready)
        else $error("ready right after allocate word");

endmodule

bind next_fit_partition_allocator nfpa_checker u_nfpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[sim/nfpa_scoreboard.sv]
`default_nettype none

module nfpa_scoreboard
    import nfpa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic              s_tuser,    // cmd
    input  wire logic [DATA_W-1:0] s_tdata,    // [3:0] block_index, [19:4] size
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic              m_tuser,    // granted
    input  wire logic [DATA_W-1:0] m_tdata,    // [3:0] block_number, [19:4] remaining
    output int                     mismatches,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] block_number;
        logic [REQ_W-1:0]   remaining;
    } grant_t;

    logic [REQ_W-1:0]   space [MAX_BLOCKS_DEF];
    logic [INDEX_W-1:0] rover;
    logic [CFG_W-1:0]   parts;
    grant_t             grants_due [$];
    int                 fails = 0;

    // circular first-fit search from the rover over the partitions in use
    function automatic grant_t place_request(input logic [REQ_W-1:0] req);
        grant_t g;
        int     n;
        int     start_at;
        int     p;
        g = '0;
        n = (parts > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(parts);
        if (n == 0) return g;
        start_at = (int'(rover) < n) ? int'(rover) : 0;
        for (int k = 0; k < n; k++) begin
            p = (start_at + k) % n;
            if (space[p] >= req) begin
                space[p]       = space[p] - req;
                rover          = INDEX_W'(p);
                g.granted      = 1'b1;
                g.block_number = INDEX_W'(p);
                g.remaining    = space[p];
                return g;
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin
        grant_t seen;
        grant_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_BLOCKS_DEF; i++) space[i] = '0;
            rover = '0;
            parts = '0;
            grants_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) parts = cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD) begin
                    space[s_tdata[INDEX_W-1:0]] = s_tdata[INDEX_W +: REQ_W];
                    rover = '0;
                end else begin
                    grants_due.push_back(place_request(s_tdata[INDEX_W +: REQ_W]));
                end
            end
            if (m_tvalid && m_tready) begin
                seen = {m_tuser, m_tdata[INDEX_W-1:0], m_tdata[INDEX_W +: REQ_W]};
                if (grants_due.size() == 0) begin
                    $error("unexpected result word: granted %0d block_number %0d remaining %0d",
                           seen.granted, seen.block_number, seen.remaining);
                    fails++;
                end else begin
                    want = grants_due.pop_front();
                    if (seen.granted !== want.granted) begin
                        $error("granted: expected %0d, actual %0d", want.granted, seen.granted);
                        fails++;
                    end
                    if (seen.block_number !== want.block_number) begin
                        $error("block_number: expected %0d, actual %0d",
                               want.block_number, seen.block_number);
                        fails++;
                    end
                    if (seen.remaining !== want.remaining) begin
                        $error("remaining: expected %0d, actual %0d",
                               want.remaining, seen.remaining);
                        fails++;
                    end
                end
            end
        end
        mismatches <= fails;
        pending    <= grants_due.size();
    end

endmodule

`default_nettype wire

[sim/next_fit_partition_allocator_test.sv]
`default_nettype none

module next_fit_partition_allocator_test;
    import nfpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = MAX_BLOCKS_DEF + 8;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tuser   = 1'b0;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic              m_tready  = 1'b0;
    logic              cfg_ready;
    logic              s_tready;
    logic              m_tvalid;
    logic              m_tuser;
    logic [DATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    bit gaps_on    = 1'b0;
    bit stalls_on  = 1'b0;
    bit calm       = 1'b0;
    int stall_left = 0;
    int mode_timer = 0;

    always #10 aclk = ~aclk;

    next_fit_partition_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    nfpa_scoreboard grant_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    // result sink: random stall bursts, switched on and off in stretches
    always @(posedge aclk) begin
        if (mode_timer == 0) begin
            mode_timer <= $urandom_range(50, 300);
            stalls_on  <= !calm && ($urandom_range(0, 2) != 0);
        end else begin
            mode_timer <= mode_timer - 1;
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stalls_on && !calm && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [REQ_W-1:0] load_size();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2, 3:    return REQ_W'($urandom);
            default: return REQ_W'($urandom_range(0, 20000));
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] alloc_amount();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return REQ_W'($urandom);
            default: return REQ_W'($urandom_range(1, 3000));
        endcase
    endfunction

    task automatic send_word(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input logic [REQ_W-1:0] amount);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= DATA_W'({amount, idx});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            s_tuser  <= 1'($urandom);
            s_tdata  <= DATA_W'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic load(input logic [INDEX_W-1:0] idx, input logic [REQ_W-1:0] amount);
        send_word(CMD_LOAD, idx, amount);
    endtask

    task automatic allocate(input logic [REQ_W-1:0] amount);
        send_word(CMD_ALLOC, INDEX_W'($urandom), amount);
    endtask

    task automatic hold_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        hold_for_results();
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int parts, input int words);
        int used;
        int pause_at;
        int n;
        write_count(CFG_W'(parts));
        used     = (parts > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : parts;
        pause_at = $urandom_range(used, words - 1);
        n        = 0;
        // fill the partitions in use first so allocations have room
        for (int i = 0; i < used; i++) begin
            load(INDEX_W'(i), load_size());
            n++;
        end
        while (n < words) begin
            if (n % 64 == 0) gaps_on = !calm && ($urandom_range(0, 2) != 0);
            if (n == pause_at) hold_for_results();
            if ($urandom_range(0, 99) < 25) load(INDEX_W'($urandom), load_size());
            else allocate(alloc_amount());
            n++;
        end
    endtask

    initial begin
        int phase_parts [5];
        phase_parts = '{16, 1, 0, 31, 16};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no partitions configured
        allocate(16'd5);
        // count above the table size, clamped
        write_count(CFG_W'(31));
        load(4'd0, 16'h0000);
        load(4'd15, 16'hFFFF);
        load(4'd7, 16'h8000);
        load(4'd3, 16'd100);
        allocate(16'h0000);
        allocate(16'hFFFF);
        allocate(16'd50);
        allocate(16'h8000);
        allocate(16'hFFFF);
        // rover left beyond the new count
        write_count(CFG_W'(4));
        allocate(16'd10);
        // load into a partition outside the count
        load(4'd12, 16'd500);
        allocate(16'd400);
        write_count(CFG_W'(16));
        allocate(16'd400);
        allocate(16'h0000);
        write_count(CFG_W'(1));
        allocate(16'h0000);
        allocate(16'd1);
        write_count(CFG_W'(0));
        allocate(16'h0000);
        load(4'd9, 16'd1);

        for (int p = 0; p < 12; p++) begin
            if (p == 11) begin
                calm    = 1'b1;
                gaps_on = 1'b0;
            end
            if (p < 5) run_phase(phase_parts[p], 165);
            else if (p == 11) run_phase(16, 165);
            else run_phase($urandom_range(0, 17), 165);
        end

        hold_for_results();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
